>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

	localparam int CAPACITY_DEF    = 512;
	localparam int WEIGHT_BITS_DEF = 32;
	localparam int SYM_BITS        = 8;
	localparam int NODE_BITS       = 9;
	localparam int FIELD_W_BITS    = 32;
	localparam int TOTAL_BITS      = 10;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                    func;
		logic [FIELD_W_BITS-1:0] in_weight;
		logic [SYM_BITS-1:0]     in_symbol;
		logic [NODE_BITS-1:0]    in_node;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [FIELD_W_BITS-1:0] out_weight;
		logic [SYM_BITS-1:0]     out_symbol;
		logic [NODE_BITS-1:0]    out_node;
		logic [TOTAL_BITS-1:0]   entry_total;
		logic                    head_valid;
		logic [FIELD_W_BITS-1:0] head_weight;
		logic [SYM_BITS-1:0]     head_symbol;
		logic [NODE_BITS-1:0]    head_node;
	} res_t;

	// symbol and node travel together through the chain
	typedef struct packed {
		logic [SYM_BITS-1:0]  symbol;
		logic [NODE_BITS-1:0] node;
	} spq_tag_t;

	// broadcast to every cell; each flag already qualified by full/empty
	typedef struct packed {
		logic ins;
		logic pop;
	} spq_ctl_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the key
// being inserted and shifts towards either neighbour. Uses spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  spq_ctl_t               ctl,
	input  logic [WEIGHT_BITS-1:0] key_weight,
	input  spq_tag_t               key_tag,
	input  logic                   occupied,
	input  logic                   prev_ahead,
	input  logic [WEIGHT_BITS-1:0] prev_weight,
	input  spq_tag_t               prev_tag,
	input  logic [WEIGHT_BITS-1:0] next_weight,
	input  spq_tag_t               next_tag,
	output logic                   ahead,
	output logic [WEIGHT_BITS-1:0] weight,
	output spq_tag_t               tag
);

	logic [WEIGHT_BITS-1:0] weight_q;
	spq_tag_t               tag_q;

	// stays ahead of the new entry: smaller weight, or equal weight and
	// symbol not larger (equal keys keep arrival order)
	assign ahead = occupied && ((weight_q < key_weight) ||
		((weight_q == key_weight) && (tag_q.symbol <= key_tag.symbol)));

	always_ff @(posedge clk) begin
		priority if (ctl.pop) begin
			weight_q <= next_weight;
			tag_q    <= next_tag;
		end else if (ctl.ins && !ahead) begin
			if (prev_ahead) begin
				weight_q <= key_weight;
				tag_q    <= key_tag;
			end else begin
				weight_q <= prev_weight;
				tag_q    <= prev_tag;
			end
		end
	end

	assign weight = weight_q;
	assign tag    = tag_q;

endmodule

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell slots, the
// entry count and the registered result. Uses spq_pkg and spq_cell.
//
// Usage:
//   A request (req, req_valid/req_stall) either inserts an entry in
//   ascending order of weight then symbol, equal keys behind those already
//   held, or pops the smallest entry. Every request gives exactly one
//   result (res, res_valid/res_stall) with a status, the popped entry (zero
//   for inserts and refused requests), the count and the head afterwards.
//   Pop on an empty queue and insert on a full one are refused and change
//   nothing.
//   res_valid rises in the cycle after acceptance. All cells compare
//   and shift in the same cycle, so one request is taken per clock while
//   the result register is empty or being drained.
//   While res_valid is high and res_stall is held, req_stall is raised and
//   the result stays put.
//   Reset empties the queue at once (count to zero); stored entries are
//   not cleared and are never read before being written.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	logic [CNT_BITS-1:0]    count_q;
	logic                   res_valid_q;
	res_t                   res_q;

	logic [WEIGHT_BITS-1:0] cell_weight [CAPACITY];
	spq_tag_t               cell_tag    [CAPACITY];
	logic                   cell_ahead  [CAPACITY];

	logic                   accept;
	logic                   full;
	logic                   empty;
	spq_ctl_t               ctl;
	logic [WEIGHT_BITS-1:0] key_weight;
	spq_tag_t               key_tag;
	logic [CNT_BITS-1:0]    count_d;
	logic [WEIGHT_BITS-1:0] head_weight;
	spq_tag_t               head_tag;
	res_t                   res_d;

	assign req_stall = res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_BITS'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.ins = accept && (req.func == FUNC_INSERT) && !full;
	assign ctl.pop = accept && (req.func == FUNC_POP) && !empty;

	assign key_weight     = WEIGHT_BITS'(req.in_weight);
	assign key_tag.symbol = req.in_symbol;
	assign key_tag.node   = req.in_node;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                   occ;
			logic                   p_ahead;
			logic [WEIGHT_BITS-1:0] p_weight;
			spq_tag_t               p_tag;
			logic [WEIGHT_BITS-1:0] n_weight;
			spq_tag_t               n_tag;

			assign occ = (CNT_BITS'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign p_ahead  = 1'b1;
				assign p_weight = key_weight;
				assign p_tag    = key_tag;
			end else begin : g_mid
				assign p_ahead  = cell_ahead[gi-1];
				assign p_weight = cell_weight[gi-1];
				assign p_tag    = cell_tag[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign n_weight = '0;
				assign n_tag    = '0;
			end else begin : g_inner
				assign n_weight = cell_weight[gi+1];
				assign n_tag    = cell_tag[gi+1];
			end

			spq_cell #(
				.WEIGHT_BITS(WEIGHT_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.key_weight (key_weight),
				.key_tag    (key_tag),
				.occupied   (occ),
				.prev_ahead (p_ahead),
				.prev_weight(p_weight),
				.prev_tag   (p_tag),
				.next_weight(n_weight),
				.next_tag   (n_tag),
				.ahead      (cell_ahead[gi]),
				.weight     (cell_weight[gi]),
				.tag        (cell_tag[gi])
			);
		end
	endgenerate

	// head and count as they will be after this request
	always_comb begin
		count_d     = count_q;
		head_weight = cell_weight[0];
		head_tag    = cell_tag[0];
		priority if (ctl.ins) begin
			count_d = count_q + CNT_BITS'(1);
			if (!cell_ahead[0]) begin
				head_weight = key_weight;
				head_tag    = key_tag;
			end
		end else if (ctl.pop) begin
			count_d     = count_q - CNT_BITS'(1);
			head_weight = cell_weight[1];
			head_tag    = cell_tag[1];
		end
	end

	always_comb begin
		res_d             = '0;
		res_d.entry_total = TOTAL_BITS'(count_d);
		res_d.head_valid  = (count_d != '0);
		if (count_d != '0) begin
			res_d.head_weight = FIELD_W_BITS'(head_weight);
			res_d.head_symbol = head_tag.symbol;
			res_d.head_node   = head_tag.node;
		end
		priority if (ctl.pop) begin
			res_d.status     = ST_DONE;
			res_d.out_weight = FIELD_W_BITS'(cell_weight[0]);
			res_d.out_symbol = cell_tag[0].symbol;
			res_d.out_node   = cell_tag[0].node;
		end else if (req.func == FUNC_POP) begin
			res_d.status = ST_EMPTY;
		end else if (full) begin
			res_d.status = ST_FULL;
		end else begin
			res_d.status = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.func == FUNC_POP) && empty) |=>
			(res_valid && (res.status == ST_EMPTY) && (count_q == '0)))
		else $error("pop on empty queue not refused");

	a_head_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.head_valid == (res.entry_total != '0) ||
			CAPACITY >= (1 << TOTAL_BITS)))
		else $error("head_valid disagrees with entry total");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without a request");

endmodule
